/* design/ilsc_pkg.sv */
// shared types and constants for the indexed list store
`timescale 1ns / 1ps

package ilsc_pkg;

   localparam int MAX_ENTRIES_DEF   = 16;
   localparam int ELEMENT_WIDTH_DEF = 32;

   // request operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_LOAD,
      CELL_SLIDE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        sel;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } state_type;

endpackage

/* design/ilsc_cell.sv */
// one position of both lists plus the sliding probe copy of the second list
`timescale 1ns / 1ps

module ilsc_cell
   import ilsc_pkg::*;
#(
   parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
   parameter int IDX           = 0
) (
   input  logic                               clock,
   input  cell_ctrl_type                      ctrl,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]   pos,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]   first_len,
   input  logic [ELEMENT_WIDTH-1:0]           value,
   input  logic [ELEMENT_WIDTH-1:0]           first_left,
   input  logic [ELEMENT_WIDTH-1:0]           first_right,
   input  logic [ELEMENT_WIDTH-1:0]           second_left,
   input  logic [ELEMENT_WIDTH-1:0]           second_right,
   input  logic [ELEMENT_WIDTH-1:0]           probe_right,
   output logic [ELEMENT_WIDTH-1:0]           first_out,
   output logic [ELEMENT_WIDTH-1:0]           second_out,
   output logic [ELEMENT_WIDTH-1:0]           probe_out,
   output logic                               match
);

   localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

   logic [ELEMENT_WIDTH-1:0] first_ff, first_in;
   logic [ELEMENT_WIDTH-1:0] second_ff, second_in;
   logic [ELEMENT_WIDTH-1:0] probe_ff, probe_in;
   logic [ELEMENT_WIDTH-1:0] own;
   logic [ELEMENT_WIDTH-1:0] left;
   logic [ELEMENT_WIDTH-1:0] right;
   logic [ELEMENT_WIDTH-1:0] shifted;

   always_comb begin
      own   = ctrl.sel ? second_ff : first_ff;
      left  = ctrl.sel ? second_left : first_left;
      right = ctrl.sel ? second_right : first_right;
      shifted = own;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_IDX > pos) begin
               shifted = left;
            end else if (MY_IDX == pos) begin
               shifted = value;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= pos) begin
               shifted = right;
            end
         end
         default: begin
            shifted = own;
         end
      endcase

      first_in  = first_ff;
      second_in = second_ff;
      if (ctrl.sel) begin
         second_in = shifted;
      end else begin
         first_in = shifted;
      end

      case (ctrl.op)
         CELL_LOAD:  probe_in = second_ff;
         CELL_SLIDE: probe_in = probe_right;
         default:    probe_in = probe_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      probe_ff  <= probe_in;
   end

   // positions past the first list's end never block a hit
   assign match      = (MY_IDX >= first_len) || (probe_ff == first_ff);
   assign first_out  = first_ff;
   assign second_out = second_ff;
   assign probe_out  = probe_ff;

endmodule

/* design/indexed_list_store_with_sublist_check_top.sv */
// two bounded lists in a chain of cells with insert, remove and sublist check
//
//   channel   direction  transfer when          payload
//   req_      in         req_valid & req_ready  operation, list_select, position, element_value
//   rsp_      out        rsp_valid & rsp_ready  status, contained, list_length
//
// insert, remove, unused codes and trivial checks give the result in the cycle after the transfer.
// a check of a non-empty first list that fits loads the probe copy of the second list, which then
// slides one place per cycle past the first list until a hit or the last start offset.
// reset clears both lengths, the state and the result valid flag; list contents are not cleared.
// one item at a time; a held result stalls the request side until it is taken.
`timescale 1ns / 1ps

module indexed_list_store_with_sublist_check_top
   import ilsc_pkg::*;
#(
   parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic                               req_list_select,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]   req_position,
   input  logic [ELEMENT_WIDTH-1:0]           req_element_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_contained,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]   rsp_list_length
);

   localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_ENTRIES);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] first_len_ff, first_len_in;
   logic [LEN_W-1:0] second_len_ff, second_len_in;
   logic [LEN_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0] limit_ff, limit_in;
   logic [LEN_W-1:0] hold_len_ff, hold_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_contained_ff, rsp_contained_in;
   logic [LEN_W-1:0] rsp_length_ff, rsp_length_in;

   cell_ctrl_type    cell_ctrl;
   logic             req_xfer;
   logic             out_free;
   logic [LEN_W-1:0] sel_len;
   logic             all_match;

   logic [ELEMENT_WIDTH-1:0] first_q  [MAX_ENTRIES];
   logic [ELEMENT_WIDTH-1:0] second_q [MAX_ENTRIES];
   logic [ELEMENT_WIDTH-1:0] probe_q  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]   match_vec;

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      localparam int LK = (k == 0) ? 0 : k - 1;
      localparam int RK = (k == MAX_ENTRIES - 1) ? k : k + 1;

      ilsc_cell #(
         .MAX_ENTRIES   (MAX_ENTRIES),
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .IDX           (k)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .pos          (req_position),
         .first_len    (first_len_ff),
         .value        (req_element_value),
         .first_left   (first_q[LK]),
         .first_right  (first_q[RK]),
         .second_left  (second_q[LK]),
         .second_right (second_q[RK]),
         .probe_right  (probe_q[RK]),
         .first_out    (first_q[k]),
         .second_out   (second_q[k]),
         .probe_out    (probe_q[k]),
         .match        (match_vec[k])
      );
   end

   assign all_match = &match_vec;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign sel_len   = req_list_select ? second_len_ff : first_len_ff;

   always_comb begin
      state_in         = state_ff;
      first_len_in     = first_len_ff;
      second_len_in    = second_len_ff;
      step_in          = step_ff;
      limit_in         = limit_ff;
      hold_len_in      = hold_len_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_contained_in = rsp_contained_ff;
      rsp_length_in    = rsp_length_ff;
      cell_ctrl.op     = CELL_HOLD;
      cell_ctrl.sel    = req_list_select;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_status_in    = STATUS_DONE;
               rsp_contained_in = 1'b0;
               rsp_length_in    = sel_len;
               rsp_valid_in     = 1'b1;
               case (req_operation)
                  OP_INSERT: begin
                     if (req_position > sel_len) begin
                        rsp_status_in = STATUS_RANGE;
                     end else if (sel_len == FULL_LEN) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_ctrl.op  = CELL_INSERT;
                        rsp_length_in = sel_len + 1'b1;
                        if (req_list_select) begin
                           second_len_in = sel_len + 1'b1;
                        end else begin
                           first_len_in = sel_len + 1'b1;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (req_position >= sel_len) begin
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        cell_ctrl.op  = CELL_REMOVE;
                        rsp_length_in = sel_len - 1'b1;
                        if (req_list_select) begin
                           second_len_in = sel_len - 1'b1;
                        end else begin
                           first_len_in = sel_len - 1'b1;
                        end
                     end
                  end
                  OP_CHECK: begin
                     if (first_len_ff == '0) begin
                        rsp_contained_in = 1'b1;
                     end else if (first_len_ff > second_len_ff) begin
                        rsp_contained_in = 1'b0;
                     end else begin
                        // slide the probe until a hit or the last start offset
                        rsp_valid_in = 1'b0;
                        cell_ctrl.op = CELL_LOAD;
                        step_in      = '0;
                        limit_in     = second_len_ff - first_len_ff;
                        hold_len_in  = sel_len;
                        state_in     = ST_CHECK;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_DONE;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               if (all_match || (step_ff == limit_ff)) begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_DONE;
                  rsp_contained_in = all_match;
                  rsp_length_in    = hold_len_ff;
                  state_in         = ST_IDLE;
               end else begin
                  cell_ctrl.op = CELL_SLIDE;
                  step_in      = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff          <= step_in;
      limit_ff         <= limit_in;
      hold_len_ff      <= hold_len_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_contained_ff <= rsp_contained_in;
      rsp_length_ff    <= rsp_length_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_contained   = rsp_contained_ff;
   assign rsp_list_length = rsp_length_ff;

endmodule

/* design/ilsc_checker.sv */
// port-level checks for the indexed list store, bound to the top level
`timescale 1ns / 1ps

module ilsc_checker
   import ilsc_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic                               rsp_contained,
   input logic [$clog2(MAX_ENTRIES+1)-1:0]   rsp_list_length
);

   localparam int LEN_W = $clog2(MAX_ENTRIES + 1);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_stalls_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while result is held");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_contained) && $stable(rsp_list_length)))
      else $error("held result changed");

   a_contained_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_contained) |-> (rsp_status == STATUS_DONE))
      else $error("containment flagged with error status");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (rsp_list_length == LEN_W'(MAX_ENTRIES)))
      else $error("full status with list not full");

endmodule

bind indexed_list_store_with_sublist_check_top ilsc_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_ilsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_contained   (rsp_contained),
   .rsp_list_length (rsp_list_length)
);

/* test/tb.sv */
// testbench for the indexed list store: directed table, then random traffic against a shadow model
`timescale 1ns / 1ps

module tb;
   import ilsc_pkg::*;

   localparam int POS_W       = $clog2(MAX_ENTRIES_DEF + 1);
   localparam int ELEM_W      = ELEMENT_WIDTH_DEF;
   localparam int RANDOM_REQS = 650;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 2 * MAX_ENTRIES_DEF;
   localparam int PEND_DEPTH  = 8;
   localparam int ROW_SLOTS   = 32;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]        operation;
      logic              list_select;
      logic [POS_W-1:0]  position;
      logic [ELEM_W-1:0] element_value;
      bit                has_exp;
      status_type        exp_status;
      logic              exp_contained;
      logic [POS_W-1:0]  exp_length;
   } list_req_type;

   typedef struct {
      status_type       status;
      logic             contained;
      logic [POS_W-1:0] length;
   } list_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_operation = OP_INSERT;
   logic              req_list_select = 1'b0;
   logic [POS_W-1:0]  req_position = '0;
   logic [ELEM_W-1:0] req_element_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic              rsp_contained;
   logic [POS_W-1:0]  rsp_list_length;

   // shadow copy of both lists: index 0 first list, index 1 second list
   logic [ELEM_W-1:0] shadow_entries [2][MAX_ENTRIES_DEF];
   int unsigned       shadow_length [2];

   // expected results in order: tail advanced by the sender, head by the monitor
   list_rsp_type      pending_results [PEND_DEPTH];
   int                pend_head;
   int                pend_tail;
   list_req_type      directed_rows [ROW_SLOTS];
   int                row_count;
   logic [ELEM_W-1:0] value_pool [4];
   int                bias_mode;
   int                error_count;
   int                idle_cycles;
   bit                steady;
   int                steady_left;
   int                stall_left;
   list_rsp_type      oldest;

   indexed_list_store_with_sublist_check_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_list_select   (req_list_select),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_contained     (rsp_contained),
      .rsp_list_length   (rsp_list_length)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("tb: mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic bit holds_sublist();
      int unsigned a, b, s, j;
      bit hit;
      a = shadow_length[0];
      b = shadow_length[1];
      if (a == 0) return 1'b1;
      if (a > b) return 1'b0;
      for (s = 0; s + a <= b; s++) begin
         hit = 1'b1;
         for (j = 0; j < a; j++)
            if (shadow_entries[1][s+j] !== shadow_entries[0][j]) hit = 1'b0;
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   // updates the shadow lists and returns the result the block should give
   function automatic list_rsp_type apply_request(input list_req_type r);
      list_rsp_type res;
      int unsigned  cnt, p, k;
      int           sel;
      sel = r.list_select;
      p = r.position;
      cnt = shadow_length[sel];
      res.status = STATUS_DONE;
      res.contained = 1'b0;
      case (r.operation)
         OP_INSERT: begin
            if (p > cnt) res.status = STATUS_RANGE;
            else if (cnt >= MAX_ENTRIES_DEF) res.status = STATUS_FULL;
            else begin
               for (k = cnt; k > p; k--) shadow_entries[sel][k] = shadow_entries[sel][k-1];
               shadow_entries[sel][p] = r.element_value;
               shadow_length[sel] = cnt + 1;
            end
         end
         OP_REMOVE: begin
            if (p >= cnt) res.status = STATUS_RANGE;
            else begin
               for (k = p; k + 1 < cnt; k++) shadow_entries[sel][k] = shadow_entries[sel][k+1];
               shadow_length[sel] = cnt - 1;
            end
         end
         OP_CHECK: res.contained = holds_sublist();
         default: ;
      endcase
      res.length = POS_W'(shadow_length[sel]);
      return res;
   endfunction

   function automatic void add_row(input logic [1:0] op, input logic sel, input int pos,
                                   input logic [ELEM_W-1:0] val, input bit typed = 1'b0,
                                   input status_type st = STATUS_DONE,
                                   input logic cont = 1'b0, input int len = 0);
      list_req_type r;
      r.operation = op;
      r.list_select = sel;
      r.position = POS_W'(pos);
      r.element_value = val;
      r.has_exp = typed;
      r.exp_status = st;
      r.exp_contained = cont;
      r.exp_length = POS_W'(len);
      directed_rows[row_count] = r;
      row_count++;
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // episodes of growth, shrinkage or balance; values mostly from a small pool
   function automatic list_req_type random_req(input int n);
      list_req_type r;
      int           pick, ins_w, rem_w, cnt, vpick;
      if (n % 40 == 0) bias_mode = $urandom_range(0, 2);
      ins_w = (bias_mode == 0) ? 70 : (bias_mode == 1) ? 15 : 40;
      rem_w = (bias_mode == 0) ? 12 : (bias_mode == 1) ? 65 : 40;
      pick = $urandom_range(0, 99);
      r.has_exp = 1'b0;
      r.exp_status = STATUS_DONE;
      r.exp_contained = 1'b0;
      r.exp_length = '0;
      if (pick < ins_w) begin
         r.operation = OP_INSERT;
         // keep the first list shorter so the sublist search finds hits
         r.list_select = ($urandom_range(0, 99) < 65);
      end else if (pick < ins_w + rem_w) begin
         r.operation = OP_REMOVE;
         r.list_select = ($urandom_range(0, 99) < 35);
      end else begin
         r.operation = (pick < 97) ? OP_CHECK : OP_UNUSED;
         r.list_select = 1'($urandom_range(0, 1));
      end
      cnt = shadow_length[r.list_select];
      if (r.operation == OP_INSERT && $urandom_range(0, 9) < 8)
         r.position = POS_W'($urandom_range(0, cnt));
      else if (r.operation == OP_REMOVE && cnt > 0 && $urandom_range(0, 9) < 8)
         r.position = POS_W'($urandom_range(0, cnt - 1));
      else
         r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      vpick = $urandom_range(0, 99);
      if (vpick < 55)
         r.element_value = value_pool[$urandom_range(0, 3)];
      else if (vpick < 80 && shadow_length[0] > 0)
         r.element_value = shadow_entries[0][$urandom_range(0, shadow_length[0] - 1)];
      else
         r.element_value = $urandom;
      return r;
   endfunction

   task automatic send_item(input list_req_type it);
      list_rsp_type predicted, typed;
      int           gap;
      gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.operation;
      req_list_select <= it.list_select;
      req_position <= it.position;
      req_element_value <= it.element_value;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(it);
      if (it.has_exp) begin
         typed.status = it.exp_status;
         typed.contained = it.exp_contained;
         typed.length = it.exp_length;
         pending_results[pend_tail % PEND_DEPTH] = typed;
      end else begin
         pending_results[pend_tail % PEND_DEPTH] = predicted;
      end
      pend_tail++;
   endtask

   initial begin
      shadow_length[0] = 0;
      shadow_length[1] = 0;
      foreach (shadow_entries[i, j]) shadow_entries[i][j] = '0;
      foreach (value_pool[i]) value_pool[i] = $urandom;
      bias_mode = 0;
      error_count = 0;
      pend_head = 0;
      pend_tail = 0;
      row_count = 0;

      // empty lists, range errors on both sides of the field, unused code
      add_row(OP_CHECK,  0, 0,  '0, 1, STATUS_DONE,  1, 0);
      add_row(OP_REMOVE, 0, 0,  '0, 1, STATUS_RANGE, 0, 0);
      add_row(OP_REMOVE, 1, 31, '1, 1, STATUS_RANGE, 0, 0);
      add_row(OP_INSERT, 0, 1,  '0, 1, STATUS_RANGE, 0, 0);
      add_row(OP_INSERT, 0, 31, '1, 1, STATUS_RANGE, 0, 0);
      add_row(OP_INSERT, 0, 0,  '0, 1, STATUS_DONE,  0, 1);
      add_row(OP_UNUSED, 1, 31, '1, 1, STATUS_DONE,  0, 0);
      // first list longer than the second
      add_row(OP_CHECK,  0, 0,  '0, 1, STATUS_DONE,  0, 1);
      add_row(OP_INSERT, 1, 0,  '1, 1, STATUS_DONE,  0, 1);
      add_row(OP_INSERT, 1, 1,  '0, 1, STATUS_DONE,  0, 2);
      add_row(OP_CHECK,  1, 0,  '0);
      // remove at the end position is out of range
      add_row(OP_REMOVE, 1, 2,  '0, 1, STATUS_RANGE, 0, 2);
      add_row(OP_INSERT, 1, 3,  '0, 1, STATUS_RANGE, 0, 2);
      add_row(OP_INSERT, 0, 1,  32'ha5a5_a5a5);
      add_row(OP_INSERT, 1, 2,  32'ha5a5_a5a5);
      add_row(OP_CHECK,  1, 0,  '0);
      add_row(OP_INSERT, 1, 1,  32'h5a5a_5a5a);
      add_row(OP_CHECK,  0, 0,  '0);
      add_row(OP_REMOVE, 1, 0,  '0);
      add_row(OP_REMOVE, 0, 0,  '0);
      add_row(OP_CHECK,  0, 0,  '0);
      add_row(OP_REMOVE, 0, 0,  '0, 1, STATUS_DONE,  0, 0);
      // empty first list is always contained
      add_row(OP_CHECK,  1, 0,  '0);
      add_row(OP_UNUSED, 0, 16, 32'h8000_0001);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < row_count; i++) send_item(directed_rows[i]);
      for (int n = 0; n < RANDOM_REQS; n++) send_item(random_req(n));
      req_valid <= 1'b0;
      while (pend_tail != pend_head) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pend_tail == pend_head) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // stretches with no idling at all on either side
   always @(posedge clock) begin
      if (steady_left == 0) begin
         steady <= ($urandom_range(0, 3) == 0);
         steady_left <= $urandom_range(50, 200);
      end else begin
         steady_left <= steady_left - 1;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
         stall_left <= pick_idle() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pend_tail == pend_head) begin
            report_mismatch("result transfer with nothing pending", rsp_status, 0);
         end else begin
            oldest = pending_results[pend_head % PEND_DEPTH];
            pend_head++;
            if (rsp_status !== oldest.status)
               report_mismatch("status", rsp_status, oldest.status);
            if (rsp_contained !== oldest.contained)
               report_mismatch("contained", rsp_contained, oldest.contained);
            if (rsp_list_length !== oldest.length)
               report_mismatch("list_length", rsp_list_length, oldest.length);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* files.f */
design/ilsc_pkg.sv
design/ilsc_cell.sv
design/indexed_list_store_with_sublist_check_top.sv
design/ilsc_checker.sv
test/tb.sv
